// ===== sv/sacd_pkg.sv =====
// Shared types and constants of the cache directory.
package sacd_pkg;

	localparam int unsigned ADDR_IN_W = 48;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned LOB_W     = 5;
	localparam int unsigned WAY_IN_W  = 4;

	localparam logic [LOB_W-1:0] LOB_RESET = 5'd12;

	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_DIRTY  = 2'd1,
		MODE_FILL   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic compare;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
	} status_t;

endpackage

// ===== sv/sacd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sacd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/sacd_ctrl.sv =====
// Sequencer of the cache directory: clear sweep, read, compare, update.
module sacd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sacd_pkg::status_t status,
	output logic              busy,
	output sacd_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CMP   = 5'b01000,
		ST_UPD   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (status.clear_done) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_READ;
			ST_READ:  state_d = ST_CMP;
			ST_CMP:   state_d = ST_UPD;
			ST_UPD:   state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.clear   = (state_q == ST_CLEAR);
	assign cmd.compare = (state_q == ST_CMP);
	assign cmd.update  = (state_q == ST_UPD);

endmodule

// ===== sv/sacd_dp.sv =====
// Datapath: set row memory, tag compare, LRU reorder, counters and result registers.
module sacd_dp #(
	parameter int unsigned SET_BITS  = 6,
	parameter int unsigned NUM_WAYS  = 4,
	parameter int unsigned ADDR_BITS = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sacd_pkg::cmd_t                     cmd,
	output sacd_pkg::status_t                  status,
	input  logic [1:0]                         mode,
	input  logic [sacd_pkg::ADDR_IN_W-1:0]     address,
	input  logic [sacd_pkg::WAY_IN_W-1:0]      way,
	input  logic                               cfg_we,
	input  logic [sacd_pkg::LOB_W-1:0]         cfg_wdata,
	output logic                               done,
	output logic                               hit,
	output logic [sacd_pkg::WAY_IN_W-1:0]      way_out,
	output logic [sacd_pkg::ADDR_IN_W-1:0]     victim_address,
	output logic                               victim_valid,
	output logic                               victim_dirty,
	output logic [sacd_pkg::CNT_W-1:0]         hit_total,
	output logic [sacd_pkg::CNT_W-1:0]         miss_total
);

	localparam int unsigned SET_W = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int unsigned NSETS = 1 << SET_BITS;
	localparam int unsigned WB    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int unsigned VB    = ADDR_BITS * NUM_WAYS;
	localparam int unsigned DB    = VB + NUM_WAYS;
	localparam int unsigned OB    = DB + NUM_WAYS;
	localparam int unsigned ROW_W = OB + NUM_WAYS * WB;
	localparam logic [63:0] AMASK = {64{1'b1}} >> (64 - ADDR_BITS);
	localparam logic [SET_W-1:0] SET_MASK = SET_W'((64'd1 << SET_BITS) - 64'd1);
	localparam logic [SET_W-1:0] SET_LAST = SET_W'(NSETS - 1);

	logic [sacd_pkg::LOB_W-1:0]     lob_q;
	logic [1:0]                     mode_q;
	logic [sacd_pkg::ADDR_IN_W-1:0] addr_q;
	logic [sacd_pkg::WAY_IN_W-1:0]  way_q;
	logic [SET_W-1:0]               clr_q;
	logic [NUM_WAYS-1:0]            match_q;
	logic [sacd_pkg::CNT_W-1:0]     hit_cnt_q, miss_cnt_q;

	logic [63:0]          a64, hmask64;
	logic [63:0]          sh64;
	logic [ADDR_BITS-1:0] a_line, hmask;
	logic [SET_W-1:0]     set_idx;

	logic [ROW_W-1:0] rd_row, upd_row, init_row, wr_row;
	logic [ADDR_BITS-1:0] r_addr [NUM_WAYS];
	logic [ADDR_BITS-1:0] n_addr [NUM_WAYS];
	logic [WB-1:0]        r_ord  [NUM_WAYS];
	logic [WB-1:0]        n_ord  [NUM_WAYS];
	logic [NUM_WAYS-1:0]  r_vld, r_drt, n_vld, n_drt, match_d;

	logic          hit_any, do_recent, wok, found, seen;
	logic [WB-1:0] hit_way, vic, rec_way, w_idx;
	logic [NUM_WAYS-1:0] shift;
	logic [63:0]   v64;

	// address split under the current line size
	assign a64     = {16'b0, addr_q} & AMASK;
	assign a_line  = ADDR_BITS'(a64 & ({64{1'b1}} << lob_q));
	assign sh64    = a64 >> lob_q;
	assign set_idx = sh64[SET_W-1:0] & SET_MASK;
	assign hmask64 = {64{1'b1}} << (6'(lob_q) + 6'(SET_BITS));
	assign hmask   = hmask64[ADDR_BITS-1:0];
	assign w_idx   = way_q[WB-1:0];
	assign wok     = ({1'b0, way_q} < 5'(NUM_WAYS));

	always_comb begin
		for (int c = 0; c < NUM_WAYS; c++) begin
			r_addr[c] = rd_row[c*ADDR_BITS +: ADDR_BITS];
			r_vld[c]  = rd_row[VB + c];
			r_drt[c]  = rd_row[DB + c];
			r_ord[c]  = rd_row[OB + c*WB +: WB];
			match_d[c] = r_vld[c] && (((r_addr[c] ^ a_line) & hmask) == '0);
		end
	end

	// update of the row: hit search in recency order, move-to-front, marks
	always_comb begin
		hit_any = 1'b0;
		hit_way = '0;
		for (int i = 0; i < NUM_WAYS; i++) begin
			if (!hit_any && match_q[r_ord[i]]) begin
				hit_any = 1'b1;
				hit_way = r_ord[i];
			end
		end
		vic = r_ord[NUM_WAYS-1];
		rec_way = (mode_q == sacd_pkg::MODE_FILL) ? w_idx : hit_way;
		do_recent = ((mode_q == sacd_pkg::MODE_LOOKUP) && hit_any) ||
			((mode_q == sacd_pkg::MODE_FILL) && wok);
		// positions up to and including the promoted way slide down by one
		seen = 1'b0;
		for (int i = 0; i < NUM_WAYS; i++) begin
			shift[i] = !seen;
			seen = seen | (r_ord[i] == rec_way);
		end
		found = seen && do_recent;
		for (int i = 0; i < NUM_WAYS; i++) begin
			n_addr[i] = r_addr[i];
			n_ord[i]  = r_ord[i];
		end
		for (int i = 1; i < NUM_WAYS; i++) begin
			if (found && shift[i]) n_ord[i] = r_ord[i-1];
		end
		if (found) n_ord[0] = rec_way;
		n_vld = r_vld;
		n_drt = r_drt;
		if (wok && (mode_q == sacd_pkg::MODE_DIRTY)) begin
			n_drt[w_idx] = 1'b1;
		end
		if (wok && (mode_q == sacd_pkg::MODE_FILL)) begin
			n_addr[w_idx] = a_line;
			n_vld[w_idx]  = 1'b1;
			n_drt[w_idx]  = 1'b0;
		end
		upd_row  = '0;
		init_row = '0;
		for (int c = 0; c < NUM_WAYS; c++) begin
			upd_row[c*ADDR_BITS +: ADDR_BITS] = n_addr[c];
			upd_row[VB + c] = n_vld[c];
			upd_row[DB + c] = n_drt[c];
			upd_row[OB + c*WB +: WB] = n_ord[c];
			init_row[OB + c*WB +: WB] = WB'(NUM_WAYS - 1 - c);
		end
	end

	assign wr_row = cmd.clear ? init_row : upd_row;
	assign v64    = 64'(r_addr[vic]);

	sacd_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NSETS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.clear || cmd.update),
		.waddr(cmd.clear ? clr_q : set_idx),
		.wdata(wr_row),
		.raddr(set_idx),
		.rdata(rd_row)
	);

	assign status.clear_done = (clr_q == SET_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lob_q      <= sacd_pkg::LOB_RESET;
			clr_q      <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			done       <= 1'b0;
		end else begin
			if (cfg_we) lob_q <= cfg_wdata;
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			done <= cmd.update;
			if (cmd.update && (mode_q == sacd_pkg::MODE_LOOKUP)) begin
				if (hit_any) hit_cnt_q <= hit_cnt_q + 1'b1;
				else         miss_cnt_q <= miss_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			addr_q <= address;
			way_q  <= way;
		end
		if (cmd.compare) match_q <= match_d;
		if (cmd.update) begin
			hit            <= 1'b0;
			way_out        <= '0;
			victim_address <= '0;
			victim_valid   <= 1'b0;
			victim_dirty   <= 1'b0;
			if (mode_q == sacd_pkg::MODE_LOOKUP) begin
				if (hit_any) begin
					hit     <= 1'b1;
					way_out <= sacd_pkg::WAY_IN_W'(hit_way);
				end else begin
					way_out        <= sacd_pkg::WAY_IN_W'(vic);
					victim_address <= v64[sacd_pkg::ADDR_IN_W-1:0];
					victim_valid   <= r_vld[vic];
					victim_dirty   <= r_drt[vic];
				end
			end
		end
	end

	assign hit_total  = hit_cnt_q;
	assign miss_total = miss_cnt_q;

endmodule

// ===== sv/set_assoc_lru_cache_directory.sv =====
// Top level of the set-associative tag directory with true LRU per set.
//
// Usage: after reset the directory sweeps its set memory once to clear it, one set
// per cycle, with busy high; a config write (line size) is taken at any time but is
// meant for idle periods. A word is taken when start is high and busy low. Each word
// runs these steps: accept, set row read from the memory, tag compare of all ways in
// parallel, then row update (LRU move-to-front, marks, fill) with the write-back. The
// result word shows up for exactly one cycle with done high, in the cycle after the
// update; it cannot be held off, so capture it then. A new word may be started in
// that same cycle. The read, compare and update steps of the sequencer, one row read
// and one row write per word, hold off a new word until the last one is through.
// The counters wrap and are also visible continuously on hit_total and miss_total.
module set_assoc_lru_cache_directory #(
	parameter int unsigned SET_BITS  = 6,
	parameter int unsigned NUM_WAYS  = 4,
	parameter int unsigned ADDR_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [47:0] address,
	input  logic [3:0]  way,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	output logic        done,
	output logic        hit,
	output logic [3:0]  way_out,
	output logic [47:0] victim_address,
	output logic        victim_valid,
	output logic        victim_dirty,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total
);

	sacd_pkg::cmd_t    cmd;
	sacd_pkg::status_t status;

	// sequencer
	sacd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.busy  (busy),
		.cmd   (cmd)
	);

	// row memory, compare and update logic
	sacd_dp #(
		.SET_BITS (SET_BITS),
		.NUM_WAYS (NUM_WAYS),
		.ADDR_BITS(ADDR_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.mode          (mode),
		.address       (address),
		.way           (way),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.hit           (hit),
		.way_out       (way_out),
		.victim_address(victim_address),
		.victim_valid  (victim_valid),
		.victim_dirty  (victim_dirty),
		.hit_total     (hit_total),
		.miss_total    (miss_total)
	);

endmodule
